// ----- src/antpe_pkg.sv -----
// antpe_pkg: shared types, register codes and helpers for the stick report converter
// no dependencies; used by every module of the block and by its checker
package antpe_pkg;

	// output modes, also the event kind of a result
	localparam logic [1:0] MODE_ABSOLUTE = 2'd0;
	localparam logic [1:0] MODE_MOTION   = 2'd1;
	localparam logic [1:0] MODE_WHEEL    = 2'd2;
	localparam logic [1:0] MODE_BUTTONS  = 2'd3;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_MODE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MOTION_GAIN      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_GAIN_X     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_GAIN_Y     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_PERIOD     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_THRESHOLD = 3'd5;

	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [1:0]         RST_OUTPUT_MODE      = MODE_ABSOLUTE;
	localparam logic signed [15:0] RST_MOTION_GAIN      = 16'sd435;
	localparam logic signed [15:0] RST_WHEEL_GAIN_X     = 16'sd20;
	localparam logic signed [15:0] RST_WHEEL_GAIN_Y     = 16'sd20;
	localparam logic [5:0]         RST_WHEEL_PERIOD     = 6'd13;
	localparam logic [5:0]         RST_BUTTON_THRESHOLD = 6'd20;

	// click stage saturation point
	localparam logic [2:0] CLICK_STAGE_MAX = 3'd7;

	typedef struct packed {
		logic [1:0]         output_mode;
		logic signed [15:0] motion_gain;
		logic signed [15:0] wheel_gain_x;
		logic signed [15:0] wheel_gain_y;
		logic [5:0]         wheel_period;
		logic [5:0]         button_threshold;
	} cfg_t;

	typedef struct packed {
		logic              sample_valid;
		logic signed [7:0] rel_x;
		logic signed [7:0] rel_y;
		logic signed [7:0] abs_x;
		logic signed [7:0] abs_y;
	} sample_t;

	typedef struct packed {
		logic               emit;
		logic [1:0]         event_kind;
		logic signed [15:0] value_x;
		logic signed [15:0] value_y;
		logic               left_button;
		logic               right_button;
	} result_t;

	// signed 17.8 product divided by 256, truncating toward zero, low 16 bits kept
	function automatic logic signed [15:0] div256(input logic signed [24:0] p);
		logic signed [24:0] biased;
		biased = p + (p[24] ? 25'sd255 : 25'sd0);
		return biased[23:8];
	endfunction

endpackage

// ----- src/antpe_cfg_regs.sv -----
// antpe_cfg_regs: configuration register file of the stick report converter
// depends on antpe_pkg for register codes, reset values and cfg_t
module antpe_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [antpe_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [antpe_pkg::CFG_DATA_W-1:0]     wr_data,
	output antpe_pkg::cfg_t                      cfg
);
	import antpe_pkg::*;

	cfg_t cfg_q;

	// register writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_mode      <= RST_OUTPUT_MODE;
			cfg_q.motion_gain      <= RST_MOTION_GAIN;
			cfg_q.wheel_gain_x     <= RST_WHEEL_GAIN_X;
			cfg_q.wheel_gain_y     <= RST_WHEEL_GAIN_Y;
			cfg_q.wheel_period     <= RST_WHEEL_PERIOD;
			cfg_q.button_threshold <= RST_BUTTON_THRESHOLD;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OUTPUT_MODE:      cfg_q.output_mode      <= wr_data[1:0];
				REG_MOTION_GAIN:      cfg_q.motion_gain      <= $signed(wr_data);
				REG_WHEEL_GAIN_X:     cfg_q.wheel_gain_x     <= $signed(wr_data);
				REG_WHEEL_GAIN_Y:     cfg_q.wheel_gain_y     <= $signed(wr_data);
				REG_WHEEL_PERIOD:     cfg_q.wheel_period     <= wr_data[5:0];
				REG_BUTTON_THRESHOLD: cfg_q.button_threshold <= wr_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/antpe_compute.sv -----
// antpe_compute: per-report datapath plus wheel divider and click stage state
// depends on antpe_pkg for cfg_t, sample_t, result_t, mode codes and div256
module antpe_compute (
	input  logic                clk,
	input  logic                arst_n,
	input  antpe_pkg::sample_t  sample,
	input  antpe_pkg::cfg_t     cfg,
	input  logic                advance,
	output antpe_pkg::result_t  res
);
	import antpe_pkg::*;

	logic [5:0] wheel_cnt_q;
	logic [2:0] click_stage_q;

	logic signed [7:0]  rx, ry, ax, ay;
	logic signed [8:0]  mul_a_x, mul_a_y;
	logic signed [15:0] mul_g_x, mul_g_y;
	logic signed [24:0] prod_x, prod_y;
	logic signed [15:0] ax16, ay16;
	logic signed [8:0]  ax9, ay9, thr9;
	logic [5:0]         wheel_cnt_inc, wheel_cnt_next;
	logic               wheel_fire;
	logic [2:0]         click_stage_next;
	logic               left_pre, right_pre, click_hold;

	// invalid report counts as all zero
	always_comb begin
		rx = sample.sample_valid ? sample.rel_x : 8'sd0;
		ry = sample.sample_valid ? sample.rel_y : 8'sd0;
		ax = sample.sample_valid ? sample.abs_x : 8'sd0;
		ay = sample.sample_valid ? sample.abs_y : 8'sd0;
	end

	// shared multiplier operands: wheel uses absolute values, motion uses relative
	always_comb begin
		if (cfg.output_mode == MODE_WHEEL) begin
			mul_a_x = 9'(ax);
			mul_a_y = 9'(ay);
			mul_g_x = cfg.wheel_gain_x;
			mul_g_y = cfg.wheel_gain_y;
		end else begin
			mul_a_x = 9'(rx);
			mul_a_y = 9'sd0 - 9'(ry);
			mul_g_x = cfg.motion_gain;
			mul_g_y = cfg.motion_gain;
		end
		prod_x = mul_a_x * mul_g_x;
		prod_y = mul_a_y * mul_g_y;
	end

	// wheel divider
	always_comb begin
		wheel_cnt_inc  = wheel_cnt_q + 6'd1;
		wheel_fire     = (wheel_cnt_inc >= cfg.wheel_period);
		wheel_cnt_next = wheel_fire ? 6'd0 : wheel_cnt_inc;
	end

	// button decision and double click stage
	always_comb begin
		ax9  = 9'(ax);
		ay9  = 9'(ay);
		thr9 = {3'b000, cfg.button_threshold};
		left_pre   = (ax9 <= (9'sd0 - thr9));
		right_pre  = !left_pre && (ax9 >= thr9);
		click_hold = (ay9 >= thr9);
		if (!click_hold)
			click_stage_next = 3'd0;
		else if (click_stage_q < CLICK_STAGE_MAX)
			click_stage_next = click_stage_q + 3'd1;
		else
			click_stage_next = click_stage_q;
	end

	// result assembly
	always_comb begin
		ax16 = 16'(ax);
		ay16 = 16'(ay);
		res = '0;
		res.event_kind = cfg.output_mode;
		res.emit = 1'b1;
		unique case (cfg.output_mode)
			MODE_MOTION: begin
				res.value_x = div256(prod_x);
				res.value_y = div256(prod_y);
			end
			MODE_WHEEL: begin
				res.emit    = wheel_fire;
				res.value_x = div256(prod_x);
				res.value_y = div256(prod_y);
			end
			MODE_BUTTONS: begin
				if (click_hold) begin
					res.right_button = 1'b0;
					case (click_stage_next) inside
						3'd1, 3'd2, 3'd5, 3'd6: res.left_button = 1'b1;
						default:                res.left_button = 1'b0;
					endcase
				end else begin
					res.left_button  = left_pre;
					res.right_button = right_pre;
				end
			end
			default: begin
				res.value_x = ax16 <<< 3;
				res.value_y = 16'sd0 - (ay16 <<< 3);
			end
		endcase
	end

	// state advances only when the report leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_cnt_q   <= '0;
			click_stage_q <= '0;
		end else if (advance) begin
			if (cfg.output_mode == MODE_WHEEL)
				wheel_cnt_q <= wheel_cnt_next;
			if (cfg.output_mode == MODE_BUTTONS)
				click_stage_q <= click_stage_next;
		end
	end

endmodule

// ----- src/analog_nub_to_pointer_events.sv -----
// analog_nub_to_pointer_events: top level, input and result registers around the datapath
// depends on antpe_pkg, antpe_cfg_regs and antpe_compute
//
// Turns analog stick reports into pointer events.
// Input channel: in_valid/in_ready with sample_valid, rel_x, rel_y, abs_x, abs_y.
// Result channel: out_valid/out_ready with event_kind, value_x, value_y,
// left_button, right_button. At most one result per report: in wheel mode
// only every wheel_period-th report produces one.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no report is in flight.
// Path: an accepted report sits in the input register, is worked out
// combinationally and lands in the result register that drives out_valid.
// Throughput: one report per cycle while the result channel does not stall,
// set by the single pass from input register to result register; the wheel
// divider and click stage update in that same cycle.
// Reset: clears both registers' valid flags, the wheel divider and click
// stage, and loads the register defaults.
// Stall: a waiting result holds; the input register still drains reports
// that give no result, and otherwise in_ready drops until out_ready returns.
module analog_nub_to_pointer_events (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               sample_valid,
	input  logic signed [7:0]                  rel_x,
	input  logic signed [7:0]                  rel_y,
	input  logic signed [7:0]                  abs_x,
	input  logic signed [7:0]                  abs_y,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         event_kind,
	output logic signed [15:0]                 value_x,
	output logic signed [15:0]                 value_y,
	output logic                               left_button,
	output logic                               right_button,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [antpe_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [antpe_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import antpe_pkg::*;

	cfg_t    cfg;
	sample_t sample_s1;
	logic    valid_s1;
	result_t res;
	result_t result_q;
	logic    out_valid_q;
	logic    out_free;
	logic    advance_s1;

	assign cfg_ready = 1'b1;

	antpe_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	antpe_compute u_compute (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_s1),
		.cfg     (cfg),
		.advance (advance_s1),
		.res     (res)
	);

	// flow control between the two registers
	assign out_free   = !out_valid_q || out_ready;
	assign advance_s1 = valid_s1 && (!res.emit || out_free);
	assign in_ready   = !valid_s1 || advance_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			sample_s1 <= '{sample_valid, rel_x, rel_y, abs_x, abs_y};
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s1 && res.emit;
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && res.emit)
			result_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = result_q.event_kind;
	assign value_x      = result_q.value_x;
	assign value_y      = result_q.value_y;
	assign left_button  = result_q.left_button;
	assign right_button = result_q.right_button;

endmodule

// ----- src/antpe_checker.sv -----
// antpe_checker: port-level checks of the stick report converter, bound to its top level
// depends on antpe_pkg for mode codes
module antpe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         event_kind,
	input logic signed [15:0] value_x,
	input logic signed [15:0] value_y,
	input logic               left_button,
	input logic               right_button
);
	import antpe_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// buttons only show in button mode
	a_buttons_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != MODE_BUTTONS |-> !left_button && !right_button)
		else $error("button set outside button mode");

	// button events carry no motion
	a_buttons_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == MODE_BUTTONS |-> value_x == 16'sd0 && value_y == 16'sd0)
		else $error("button event with nonzero values");

	// left and right never together
	a_one_button: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(left_button && right_button))
		else $error("both buttons set");

endmodule

bind analog_nub_to_pointer_events antpe_checker u_antpe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.event_kind   (event_kind),
	.value_x      (value_x),
	.value_y      (value_y),
	.left_button  (left_button),
	.right_button (right_button)
);
